// ----- hdl/ped_pkg.sv -----
// Package: types and constants for the parabola envelope row pass.
`default_nettype none
package ped_pkg;
  localparam int unsigned DistW = 22;
  localparam int unsigned LenW = 11;
  localparam logic [DistW-1:0] DistMax = 22'h3FFFFF;

  localparam logic [0:0] CmdLoad = 1'b0;
  localparam logic [0:0] CmdDrain = 1'b1;

  localparam logic [0:0] RegRowLength = 1'b0;
  localparam logic [0:0] RegEmptyMarker = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StLdRead,
    StLdWait,
    StLdCalc,
    StLdDiv,
    StLdCheck,
    StLdPush,
    StDrRead,
    StDrWait,
    StDrCheck,
    StDrOut,
    StOut
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

// ----- hdl/ped_if.sv -----
// Interface: valid/ready channel carrying a payload of parameterized width.
`default_nettype none
interface ped_if #(
  parameter int unsigned W = 1
) (
  input wire logic clk_i
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ped_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ped_div
  import ped_pkg::*;
#(
  parameter int unsigned NW = 36,
  parameter int unsigned DW = 14
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output div_ctl_t           ctl_o,
  output logic      [NW-1:0] quot_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quot_q, quot_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;
  logic [DW+1:0] sub;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DW-1:0], quot_q[NW-1]};
    sub    = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!sub[DW+1]) begin
        rem_d = sub[DW:0];
      end else begin
        rem_d = trial;
      end
      quot_d = {quot_q[NW-2:0], ~sub[DW+1]};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
  assign quot_o      = quot_q;
endmodule
`default_nettype wire

// ----- hdl/parabola_envelope_distance_row.sv -----
// Top level: one row pass of the labelled squared-distance transform.
//   channel | dir | payload
//   in_ch   | in  | command, sample_value, sample_tag
//   out_ch  | out | distance_sq, point_tag, found, last
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// Load: StLdRead, StLdWait, StLdCalc, StLdDiv (NW = 26 quotient bits, not on a negative
// difference), StLdCheck, back to StLdRead per pop, then StLdPush; an empty stack goes
// straight to StLdPush, a skipped or surplus sample stays in StIdle. Drain: StDrRead,
// StDrWait, StDrCheck per stack step walked, StDrOut, then StOut until ready (empty: StOut).
// Ready is low while an item is in work or its result waits; reset clears the
// row counters and the stack count, the stack memory itself is not cleared.
`default_nettype none
module parabola_envelope_distance_row
  import ped_pkg::*;
#(
  parameter int unsigned MAX_LEN  = 1024,
  parameter int unsigned TAG_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ped_if.sink              in_ch,
  ped_if.source            out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [21:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  // position < MAX_LEN <= 4096: square < 2^24; sum <= 2^22 + 2^24
  localparam int unsigned PW = 13;
  localparam int unsigned NW = 26;
  localparam int unsigned DW = 14;
  localparam int unsigned EW = PW + PW + DistW + TAG_BITS;

  logic [LenW-1:0]  row_len_q;
  logic [DistW-1:0] marker_q;
  logic [PW-1:0]    len_eff;

  always_comb begin
    if (row_len_q == '0) begin
      len_eff = PW'(1);
    end else if ({2'b00, row_len_q} > PW'(MAX_LEN)) begin
      len_eff = PW'(MAX_LEN);
    end else begin
      len_eff = {2'b00, row_len_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= LenW'(1024);
      marker_q  <= 22'd2097152;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRowLength:   row_len_q <= cfg_data_i[LenW-1:0];
        RegEmptyMarker: marker_q  <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // stack memory: centre, left bound, value, tag
  logic [EW-1:0] mem [MAX_LEN];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en;
  logic          wr_en;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  logic [PW-1:0]     rd_centre, rd_lb;
  logic [DistW-1:0]  rd_val;
  logic [TAG_BITS-1:0] rd_tag;
  assign {rd_centre, rd_lb, rd_val, rd_tag} = rd_q;

  state_e state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [PW-1:0]       lpos_q, lpos_d, dpos_q, dpos_d;
  logic [AW-1:0]       dptr_q, dptr_d;
  logic [DistW-1:0]    sv_q, sv_d;
  logic [TAG_BITS-1:0] st_q, st_d;
  logic [PW-1:0]       i_q, i_d;
  logic [PW:0]         s_q, s_d;
  logic                neg_q, neg_d;
  logic [NW-1:0]       num_q, num_d;
  logic [DW-1:0]       den_q, den_d;
  logic [DistW-1:0]    odist_q, odist_d;
  logic [TAG_BITS-1:0] otag_q, otag_d;
  logic                ofound_q, ofound_d, olast_q, olast_d;
  logic [PW-1:0]       cen_q, cen_d;
  logic [DistW-1:0]    val_q, val_d;
  logic                div_go;
  div_ctl_t            div_ctl;
  logic [NW-1:0]       quot;

  ped_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go),
    .num_i  (num_d),
    .den_i  (den_d),
    .ctl_o  (div_ctl),
    .quot_o (quot)
  );

  logic                in_cmd;
  logic [DistW-1:0]    in_val;
  logic [15:0]         in_tag;
  assign {in_cmd, in_val, in_tag} = in_ch.data;

  logic [2*PW-1:0] isq, jsq, dsq;
  logic [NW:0]     lhs, rhs;
  logic [PW-1:0]   dd;
  logic [NW:0]     rsum;

  always_comb begin
    isq  = i_q * i_q;
    jsq  = rd_centre * rd_centre;
    lhs  = (NW+1)'(sv_q) + (NW+1)'(isq);
    rhs  = (NW+1)'(rd_val) + (NW+1)'(jsq);
    dd   = (dpos_q >= cen_q) ? dpos_q - cen_q : cen_q - dpos_q;
    dsq  = dd * dd;
    rsum = (NW+1)'(val_q) + (NW+1)'(dsq);
  end

  logic [DistW-1:0] fin_dist;
  assign fin_dist = (rsum > (NW+1)'(DistMax)) ? DistMax : rsum[DistW-1:0];

  // next stack entry still starts at or before the drained position
  logic dr_adv;
  assign dr_adv = (CW'(dptr_q) + CW'(1) < cnt_q) && ({1'b0, rd_lb} <= {1'b0, dpos_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_ch.valid) begin
          if (in_cmd == CmdDrain) state_d = (cnt_q == '0) ? StOut : StDrRead;
          else if (lpos_q >= len_eff) state_d = StIdle;
          else if (in_val == marker_q) state_d = StIdle;
          else state_d = StLdRead;
        end
      end
      StLdRead:  state_d = (cnt_q == '0) ? StLdPush : StLdWait;
      StLdWait:  state_d = StLdCalc;
      StLdCalc:  state_d = neg_d ? StLdCheck : StLdDiv;
      StLdDiv:   state_d = div_ctl.done ? StLdCheck : StLdDiv;
      StLdCheck: begin
        if (s_q > {1'b0, rd_lb}) state_d = StLdPush;
        else state_d = (cnt_q == CW'(1)) ? StLdPush : StLdRead;
      end
      StLdPush:  state_d = StIdle;
      StDrRead:  state_d = StDrWait;
      StDrWait:  state_d = StDrCheck;
      StDrCheck: state_d = dr_adv ? StDrCheck : StDrOut;
      StDrOut:   state_d = StOut;
      StOut:     state_d = out_ch.ready ? StIdle : StOut;
      default:   state_d = StIdle;
    endcase
  end

  // datapath / outputs
  always_comb begin
    cnt_d = cnt_q; lpos_d = lpos_q; dpos_d = dpos_q; dptr_d = dptr_q;
    sv_d = sv_q; st_d = st_q; i_d = i_q; s_d = s_q; neg_d = neg_q;
    num_d = num_q; den_d = den_q; odist_d = odist_q; otag_d = otag_q;
    ofound_d = ofound_q; olast_d = olast_q; cen_d = cen_q; val_d = val_q;
    div_go = 1'b0; wr_en = 1'b0; rd_en = 1'b0;
    rd_addr = '0; wr_addr = cnt_q[AW-1:0];
    wr_data = {i_q, s_q[PW-1:0], sv_q, st_q};
    in_ch.ready = (state_q == StIdle);
    case (state_q)
      StIdle: begin
        if (in_ch.valid) begin
          if (in_cmd == CmdDrain) begin
            olast_d  = (dpos_q + PW'(1) >= len_eff);
            ofound_d = 1'b0;
            odist_d  = marker_q;
            otag_d   = '0;
            if (cnt_q != '0 && {{(PW-AW){1'b0}}, dptr_q} >= PW'(cnt_q)) begin
              dptr_d = AW'(cnt_q - CW'(1));
            end
            if (cnt_q == '0 && olast_d) begin
              lpos_d = '0; dpos_d = '0; dptr_d = '0;
            end else if (cnt_q == '0) begin
              dpos_d = dpos_q + PW'(1);
            end
          end else if (lpos_q < len_eff) begin
            i_d    = lpos_q;
            lpos_d = lpos_q + PW'(1);
            sv_d   = in_val;
            st_d   = TAG_BITS'(in_tag);
            s_d    = '0;
          end
        end
      end
      StLdRead: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_q - CW'(1));
      end
      StLdCalc: begin
        neg_d = lhs < rhs;
        num_d = NW'(lhs - rhs);
        den_d = (i_q > rd_centre) ? DW'({i_q - rd_centre, 1'b0}) : DW'(1);
        if (neg_d) s_d = '0;
        else div_go = 1'b1;
      end
      StLdDiv: begin
        if (div_ctl.done) begin
          if (quot >= NW'(len_eff)) s_d = {1'b0, len_eff};
          else s_d = (PW+1)'(quot) + (PW+1)'(1);
        end
      end
      StLdCheck: begin
        if (s_q <= {1'b0, rd_lb}) cnt_d = cnt_q - CW'(1);
      end
      StLdPush: begin
        if (s_q < {1'b0, len_eff} && cnt_q < CW'(MAX_LEN)) begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
      end
      StDrRead: begin
        rd_en   = 1'b1;
        rd_addr = dptr_q;
      end
      StDrWait: begin
        cen_d = rd_centre; val_d = rd_val; otag_d = rd_tag;
        rd_en   = 1'b1;
        rd_addr = dptr_q + AW'(1);
      end
      StDrCheck: begin
        if (dr_adv) begin
          dptr_d = dptr_q + AW'(1);
          cen_d = rd_centre; val_d = rd_val; otag_d = rd_tag;
          rd_en   = 1'b1;
          rd_addr = dptr_q + AW'(2);
        end
      end
      StDrOut: begin
        odist_d  = fin_dist;
        ofound_d = 1'b1;
      end
      StOut: begin
        if (out_ch.ready && ofound_q) begin
          if (olast_q) begin
            cnt_d = '0; lpos_d = '0; dpos_d = '0; dptr_d = '0;
          end else begin
            dpos_d = dpos_q + PW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; lpos_q <= '0; dpos_q <= '0; dptr_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q  <= cnt_d;
      lpos_q <= lpos_d;
      dptr_q <= dptr_d;
      dpos_q <= dpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sv_q <= sv_d; st_q <= st_d; i_q <= i_d; s_q <= s_d; neg_q <= neg_d;
    num_q <= num_d; den_q <= den_d; otag_q <= otag_d;
    olast_q <= olast_d; cen_q <= cen_d; val_q <= val_d;
    ofound_q <= ofound_d;
    odist_q <= odist_d;
  end

  assign out_ch.valid = (state_q == StOut);
  assign out_ch.data  = {odist_q, 16'(otag_q), ofound_q, olast_q};
  logic unused;
  assign unused = ^{div_ctl.start, div_ctl.busy};
endmodule
`default_nettype wire

// ----- tb/parabola_envelope_distance_row_test.sv -----
// Testbench: random and directed row passes of the parabola envelope block.
`timescale 1ns / 100ps
module parabola_envelope_distance_row_test
  import ped_pkg::*;
;
  localparam int unsigned MaxLen = 1024;
  localparam int unsigned InW = 39;
  localparam int unsigned OutW = 40;
  localparam int unsigned IdleLimit = 200000;
  localparam logic [21:0] ValTop = 22'h3FFFFF;

  typedef struct packed {
    logic [21:0] distance_sq;
    logic [15:0] point_tag;
    logic        found;
    logic        last;
  } row_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [21:0] cfg_data_i = '0;

  ped_if #(.W(InW)) in_ch (.clk_i(clk_i));
  ped_if #(.W(OutW)) out_ch (.clk_i(clk_i));

  parabola_envelope_distance_row dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // envelope model state
  longint env_centre [MaxLen];
  longint env_lbound [MaxLen];
  longint env_value [MaxLen];
  logic [15:0] env_tag [MaxLen];
  int env_count, env_lpos, env_dpos, env_dptr;
  logic [10:0] env_row_len = 11'd1024;
  logic [21:0] env_marker = 22'd2097152;

  logic [InW-1:0] pending_items [$];
  row_result_t envelope_results [$];
  bit failed = 0;
  int accepted_results = 0;

  function automatic int span_of(logic [10:0] n);
    if (n == 0) return 1;
    if (n > MaxLen) return MaxLen;
    return n;
  endfunction

  function automatic void envelope_step(logic [InW-1:0] item);
    logic cmd;
    logic [21:0] v;
    logic [15:0] tg;
    int len;
    longint i, j, s, diff, den, pos, d, r;
    row_result_t res;
    {cmd, v, tg} = item;
    len = span_of(env_row_len);
    if (cmd == CmdLoad) begin
      if (env_lpos >= len) return;
      i = env_lpos;
      env_lpos++;
      if (v == env_marker) return;
      s = 0;
      while (env_count > 0) begin
        j = env_centre[env_count-1];
        diff = (longint'(v) + i * i) - (env_value[env_count-1] + j * j);
        den = 2 * (i - j);
        if (den <= 0) den = 1;
        s = (diff < 0) ? 0 : diff / den + 1;
        if (s > env_lbound[env_count-1]) break;
        env_count--;
      end
      if (s < len && env_count < MaxLen) begin
        env_centre[env_count] = i;
        env_lbound[env_count] = s;
        env_value[env_count] = v;
        env_tag[env_count] = tg;
        env_count++;
      end
      return;
    end
    res = '0;
    if (env_count == 0) begin
      res.distance_sq = env_marker;
    end else begin
      pos = env_dpos;
      if (env_dptr >= env_count) env_dptr = env_count - 1;
      while (env_dptr + 1 < env_count && env_lbound[env_dptr+1] <= pos) env_dptr++;
      d = pos - env_centre[env_dptr];
      r = env_value[env_dptr] + d * d;
      res.distance_sq = (r > ValTop) ? ValTop : r[21:0];
      res.point_tag = env_tag[env_dptr];
      res.found = 1'b1;
    end
    res.last = (env_dpos + 1 >= len);
    if (res.last) begin
      env_count = 0; env_lpos = 0; env_dpos = 0; env_dptr = 0;
    end else begin
      env_dpos++;
    end
    envelope_results.push_back(res);
  endfunction

  // sender: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        envelope_step(in_ch.data);
        void'(pending_items.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_items[0];
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  int hold_left = 0;
  bit held_once = 0;
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase++;
      if (!held_once && accepted_results >= 60) begin
        held_once = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if ((stall_phase / 200) % 3 == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // monitor
  row_result_t got, want;
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      accepted_results++;
      if (envelope_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1;
      end else begin
        want = envelope_results.pop_front();
        if (got.distance_sq !== want.distance_sq) begin
          $display("%0t: distance_sq exp %0d got %0d", $time, want.distance_sq, got.distance_sq);
          failed = 1;
        end
        if (got.point_tag !== want.point_tag) begin
          $display("%0t: point_tag exp %0d got %0d", $time, want.point_tag, got.point_tag);
          failed = 1;
        end
        if (got.found !== want.found) begin
          $display("%0t: found exp %0b got %0b", $time, want.found, got.found);
          failed = 1;
        end
        if (got.last !== want.last) begin
          $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
          failed = 1;
        end
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus side row tracking
  int row_len, row_lpos, row_dpos;

  task automatic push_load(logic [21:0] v, logic [15:0] tg);
    pending_items.push_back({CmdLoad, v, tg});
    if (row_lpos < row_len) row_lpos++;
  endtask

  task automatic push_drain(output bit ended);
    pending_items.push_back({CmdDrain, 22'd0, 16'($urandom)});
    ended = (row_dpos + 1 >= row_len);
    if (ended) begin
      row_lpos = 0; row_dpos = 0;
    end else row_dpos++;
  endtask

  task automatic finish_row();
    bit ended;
    ended = 0;
    while (!ended) push_drain(ended);
  endtask

  task automatic set_phase(logic [10:0] rl, logic [21:0] mk);
    wait (pending_items.size() == 0 && envelope_results.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= RegRowLength; cfg_data_i <= 22'(rl);
    @(posedge clk_i);
    cfg_idx_i <= RegEmptyMarker; cfg_data_i <= mk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    env_row_len = rl; env_marker = mk;
    row_len = span_of(rl); row_lpos = 0; row_dpos = 0;
  endtask

  function automatic logic [21:0] pick_value(int pos);
    case ($urandom_range(0, 9))
      0: return env_marker;
      1: return ValTop - 22'($urandom_range(0, 3));
      2: return 22'($urandom);
      3: return 22'(pos * pos);
      default: return 22'($urandom_range(0, 60));
    endcase
  endfunction

  task automatic random_row(bit well_formed);
    bit ended;
    int extra;
    extra = well_formed ? 0 : $urandom_range(0, 3);
    for (int k = 0; k < row_len + extra; k++) begin
      if (!well_formed && $urandom_range(0, 5) == 0) begin
        push_drain(ended);
        if (ended) return;
      end
      push_load(pick_value(k), 16'($urandom));
    end
    finish_row();
  endtask

  bit ended_dummy;
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    row_len = 1024; row_lpos = 0; row_dpos = 0;

    // empty row, marker skip, saturation, surplus samples and zero length
    set_phase(11'd1, 22'd2097152);
    push_load(22'd2097152, 16'hFFFF); finish_row();
    push_load(ValTop, 16'hFFFF); finish_row();
    push_load(22'd0, 16'h0000); push_load(22'd5, 16'h1234); finish_row();
    set_phase(11'd0, 22'd0);
    push_load(22'd0, 16'h0001); finish_row();
    push_load(22'd7, 16'hA5A5); finish_row();
    // ties between equal parabolas, drain before the row is loaded
    set_phase(11'd4, ValTop);
    push_load(22'd0, 16'd1); push_load(ValTop, 16'd2); push_load(22'd0, 16'd3);
    push_drain(ended_dummy); push_drain(ended_dummy);
    push_load(22'd0, 16'd4); finish_row();
    push_load(22'd9, 16'd5); push_load(22'd0, 16'd6); push_drain(ended_dummy);
    push_load(22'd0, 16'd7); push_load(22'd0, 16'd8); push_load(22'd1, 16'd9);
    finish_row();

    for (int p = 0; p < 18; p++) begin
      case ($urandom_range(0, 3))
        0: set_phase(11'($urandom_range(1, 3)), 22'd0);
        1: set_phase(11'($urandom_range(2, 12)), 22'($urandom));
        default: set_phase(11'($urandom_range(1, 8)), 22'd2097152);
      endcase
      for (int r = 0; r < 3; r++) random_row($urandom_range(0, 3) != 0);
    end

    // length saturated, then the open row is ended under a length of one
    set_phase(11'd2047, ValTop);
    for (int k = 0; k < 40; k++)
      push_load(($urandom_range(0, 1) == 0) ? 22'($urandom_range(0, 3000)) :
                22'($urandom_range(0, 4194302)), 16'($urandom));
    for (int k = 0; k < 40; k++) push_drain(ended_dummy);
    set_phase(11'd1, 22'd2097152);
    finish_row();
    set_phase(11'd60, 22'd2097152);
    for (int k = 0; k < 30; k++) push_load(pick_value(k), 16'($urandom));
    finish_row();

    set_phase(11'd5, 22'd3);
    random_row(1);
    wait (pending_items.size() == 0 && envelope_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!failed) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- parabola_envelope_distance_row.f -----
hdl/ped_pkg.sv
hdl/ped_if.sv
hdl/ped_div.sv
hdl/parabola_envelope_distance_row.sv
tb/parabola_envelope_distance_row_test.sv
